// ===== rtl/dwpl_pkg.sv =====
// Package for the dual-wheel PID line follower: types, constants, states.
// Used by dwpl_ctrl, dwpl_dp and the top level.
package dwpl_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 48;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LEFT_GAINS   = 3'd0,
		REG_RIGHT_GAINS  = 3'd1,
		REG_COLOUR_GAINS = 3'd2,
		REG_RED_CAL      = 3'd3,
		REG_GREEN_CAL    = 3'd4,
		REG_BLUE_CAL     = 3'd5,
		REG_DRIVE_LIMITS = 3'd6,
		REG_NONE         = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_STEP       = 3'd0,
		MODE_LEFT_UP    = 3'd1,
		MODE_LEFT_DOWN  = 3'd2,
		MODE_RIGHT_UP   = 3'd3,
		MODE_RIGHT_DOWN = 3'd4,
		MODE_RSV5       = 3'd5,
		MODE_RSV6       = 3'd6,
		MODE_RSV7       = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,     // wheel errors, start red divide
		ST_DIV,     // divider running
		ST_DIVNEXT, // store quotient, start next channel if any
		ST_AVG,     // colour error average and integrals
		ST_MUL,     // nine gain products, one per cycle
		ST_SUM,     // drive sums
		ST_CLAMP,   // drive clamp into output register
		ST_OUT      // result waits for the sink
	} state_t;

	// Datapath commands from the controller
	typedef struct packed {
		logic       start;    // latch item, compute wheel errors
		logic       div_load; // load divider for channel sel
		logic       div_store;
		logic [1:0] chan;
		logic       avg;
		logic       mul_en;
		logic [3:0] mul_idx;
		logic       sum;
		logic       clamp;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_sts_t;

	localparam int unsigned NumProducts = 9;
endpackage

// ===== rtl/dual_wheel_pid_line_follower.sv =====
// Top level of the dual-wheel PID line follower: ports, config registers.
// Depends on dwpl_pkg, dwpl_ctrl, dwpl_dp.
//
// Channel | Dir | Payload
// s_axis  | in  | tuser: mode[2:0]; tdata: target[15:0], red[23:16], green[31:24],
//         |     | blue[39:32]
// m_axis  | out | tdata: left_drive, right_drive, aligned, left_count, right_count
// cfg     | in  | cfg_index[2:0], cfg_data[47:0]
//
// A control item raises m_axis_tvalid once it has been accepted and has passed
// through a latch step, three divides (24 quotient bits each, then a store),
// an average step, nine products through one shared multiplier, then sum and
// clamp. Encoder items give no result.
// The result is held until m_axis_tready; a new item is accepted in the same cycle
// it leaves. Reset restores all counts, integrals and calibration defaults at once.
module dual_wheel_pid_line_follower (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,  // mode
	input  logic [39:0] s_axis_tdata,  // target, red, green, blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // left_drive, right_drive, aligned_flag,
	                                   // left_count, right_count; zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	logic [47:0] lg_q, rg_q, cg_q;
	logic [23:0] rc_q, gc_q, bc_q;
	logic [15:0] lim_q;
	logic        in_fire;
	dwpl_pkg::dp_cmd_t cmd;
	dwpl_pkg::dp_sts_t sts;
	logic [7:0]  ld, rd;
	logic        al;
	logic signed [15:0] lc, rc;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= '0; rg_q <= '0; cg_q <= '0;
			rc_q <= 24'd1969769; gc_q <= 24'd1970050; bc_q <= 24'd2298259;
			lim_q <= 16'd7830;
		end else if (cfg_valid) begin
			unique case (dwpl_pkg::reg_idx_t'(cfg_index))
				dwpl_pkg::REG_LEFT_GAINS:   lg_q <= cfg_data;
				dwpl_pkg::REG_RIGHT_GAINS:  rg_q <= cfg_data;
				dwpl_pkg::REG_COLOUR_GAINS: cg_q <= cfg_data;
				dwpl_pkg::REG_RED_CAL:      rc_q <= cfg_data[23:0];
				dwpl_pkg::REG_GREEN_CAL:    gc_q <= cfg_data[23:0];
				dwpl_pkg::REG_BLUE_CAL:     bc_q <= cfg_data[23:0];
				dwpl_pkg::REG_DRIVE_LIMITS: lim_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	dwpl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_mode (s_axis_tuser),
		.in_rdy  (s_axis_tready),
		.out_vld (m_axis_tvalid),
		.out_rdy (m_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	dwpl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cnt_en       (in_fire),
		.in_mode      (s_axis_tuser),
		.in_target    (s_axis_tdata[15:0]),
		.in_red       (s_axis_tdata[23:16]),
		.in_green     (s_axis_tdata[31:24]),
		.in_blue      (s_axis_tdata[39:32]),
		.left_gains   (lg_q),
		.right_gains  (rg_q),
		.colour_gains (cg_q),
		.red_cal      (rc_q),
		.green_cal    (gc_q),
		.blue_cal     (bc_q),
		.limits       (lim_q),
		.left_drive   (ld),
		.right_drive  (rd),
		.aligned      (al),
		.left_count   (lc),
		.right_count  (rc)
	);

	assign m_axis_tdata = {7'd0, rc, lc, al, rd, ld};
endmodule

// ===== rtl/dwpl_div.sv =====
// Restoring signed divider, one quotient bit per cycle.
// Depends on nothing; used by dwpl_dp for the colour unit errors.
module dwpl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic signed [23:0] dividend, // e * 2^14
	input  logic signed [8:0]  divisor,
	output logic               done,
	output logic signed [23:0] quotient  // truncated toward zero
);
	logic [23:0] rem_q;
	logic [23:0] quo_q;
	logic [8:0]  den_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [24:0] trial;
	logic [23:0] shifted;

	assign shifted = {rem_q[22:0], quo_q[23]};
	assign trial = {1'b0, shifted} - {16'd0, den_q};

	// One bit per cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd24;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend[23] ? 24'(-dividend) : dividend;
			den_q <= divisor[8] ? 9'(-divisor) : divisor;
			neg_q <= dividend[23] ^ divisor[8];
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	// Quotient holds until the next load
	assign done = !busy_q;
	assign quotient = neg_q ? 24'(-quo_q) : quo_q;
endmodule

// ===== rtl/dwpl_dp.sv =====
// Datapath: encoder counts, PID state, divider, shared multiplier, clamp.
// Depends on dwpl_pkg and dwpl_div.
module dwpl_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwpl_pkg::dp_cmd_t     cmd,
	output dwpl_pkg::dp_sts_t     sts,
	input  logic                  cnt_en,
	input  logic [2:0]            in_mode,
	input  logic signed [15:0]    in_target,
	input  logic [7:0]            in_red,
	input  logic [7:0]            in_green,
	input  logic [7:0]            in_blue,
	input  logic [47:0]           left_gains,
	input  logic [47:0]           right_gains,
	input  logic [47:0]           colour_gains,
	input  logic [23:0]           red_cal,
	input  logic [23:0]           green_cal,
	input  logic [23:0]           blue_cal,
	input  logic [15:0]           limits,
	output logic [7:0]            left_drive,
	output logic [7:0]            right_drive,
	output logic                  aligned,
	output logic signed [15:0]    left_count,
	output logic signed [15:0]    right_count
);
	localparam logic signed [31:0] I32Max = 32'sh7fffffff;
	localparam logic signed [31:0] I32Min = 32'sh80000000;
	localparam logic signed [63:0] Q22One = 64'sd4194304;

	logic signed [15:0] lcnt_q, rcnt_q;
	logic signed [31:0] li_q, ri_q, ci_q;
	logic signed [15:0] lpe_q, rpe_q, cpe_q;
	logic signed [15:0] el_q, er_q, ec_q;
	logic [7:0]         rd_q, gr_q, bl_q;
	logic signed [15:0] ue_q [3];
	logic signed [63:0] acc_l_q, acc_r_q, acc_c_q;
	logic signed [63:0] left_s_q, right_s_q;
	logic signed [15:0] tgt_q;

	// Encoder counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= '0;
			rcnt_q <= '0;
		end else if (cnt_en) begin
			unique case (dwpl_pkg::mode_t'(in_mode))
				dwpl_pkg::MODE_LEFT_UP:    lcnt_q <= lcnt_q + 16'sd1;
				dwpl_pkg::MODE_LEFT_DOWN:  lcnt_q <= lcnt_q - 16'sd1;
				dwpl_pkg::MODE_RIGHT_UP:   rcnt_q <= rcnt_q + 16'sd1;
				dwpl_pkg::MODE_RIGHT_DOWN: rcnt_q <= rcnt_q - 16'sd1;
				default: ;
			endcase
		end
	end

	// Wheel errors, saturated
	logic signed [16:0] dl, dr;
	assign dl = 17'(in_target) - 17'(lcnt_q);
	assign dr = 17'(in_target) - 17'(rcnt_q);

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767) return 16'sh7fff;
		if (v < -17'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// Divider operands for the selected channel
	logic [7:0]         rsel;
	logic [23:0]        csel;
	logic signed [9:0]  e;
	logic signed [9:0]  span;
	logic signed [23:0] dquo;
	logic               ddone;
	always_comb begin
		case (cmd.chan)
			2'd0:    begin rsel = rd_q; csel = red_cal; end
			2'd1:    begin rsel = gr_q; csel = green_cal; end
			default: begin rsel = bl_q; csel = blue_cal; end
		endcase
		e = 10'({2'b0, rsel}) - 10'({2'b0, csel[23:16]});
		span = e[9] ? 10'({2'b0, csel[23:16]}) - 10'({2'b0, csel[15:8]})
			: 10'({2'b0, csel[7:0]}) - 10'({2'b0, csel[23:16]});
	end

	logic       zero_q;
	logic [1:0] dchan_q;
	dwpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend ({e, 14'd0}),
		.divisor  (span[8:0]),
		.done     (ddone),
		.quotient (dquo)
	);
	assign sts.div_done = ddone;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tgt_q <= in_target;
			rd_q  <= in_red;
			gr_q  <= in_green;
			bl_q  <= in_blue;
			el_q  <= sat16(dl);
			er_q  <= sat16(dr);
		end
		// Channel and zero case travel with the running divide
		if (cmd.div_load) begin
			zero_q  <= (e == 10'sd0) || (span == 10'sd0);
			dchan_q <= cmd.chan;
		end
		if (cmd.div_store) begin
			if (zero_q) ue_q[dchan_q] <= '0;
			else if (dquo > 24'sd32767) ue_q[dchan_q] <= 16'sh7fff;
			else if (dquo < -24'sd32768) ue_q[dchan_q] <= 16'sh8000;
			else ue_q[dchan_q] <= dquo[15:0];
		end
	end

	// Average by 3: exact for |sum| < 2^17 via reciprocal 43691/2^17
	logic signed [17:0] usum;
	logic [16:0]        uabs;
	logic [33:0]        uprod;
	logic [15:0]        uq;
	logic signed [15:0] ec_n;
	assign usum = 18'(ue_q[0]) + 18'(ue_q[1]) + 18'(ue_q[2]);
	assign uabs = usum[17] ? 17'(-usum) : usum[16:0];
	assign uprod = 34'(uabs) * 34'd43691;
	assign uq = uprod[32:17];
	assign ec_n = usum[17] ? 16'(-uq) : uq;

	function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
			input logic signed [15:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'(I32Max)) return I32Max;
		if (s < 33'(I32Min)) return I32Min;
		return s[31:0];
	endfunction

	// PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			li_q <= '0; ri_q <= '0; ci_q <= '0;
			lpe_q <= '0; rpe_q <= '0; cpe_q <= '0;
		end else begin
			if (cmd.avg) begin
				li_q <= sadd(li_q, el_q);
				ri_q <= sadd(ri_q, er_q);
				ci_q <= sadd(ci_q, ec_n);
			end
			if (cmd.sum) begin
				lpe_q <= el_q;
				rpe_q <= er_q;
				cpe_q <= ec_q;
			end
		end
	end

	// Shared 16x33 multiplier, one product per cycle
	logic signed [15:0] mg;
	logic signed [32:0] mx;
	logic signed [48:0] mp;
	always_comb begin
		case (cmd.mul_idx)
			4'd0: begin mg = colour_gains[47:32]; mx = 33'(ec_q); end
			4'd1: begin mg = colour_gains[31:16]; mx = 33'(ci_q); end
			4'd2: begin mg = colour_gains[15:0];  mx = 33'(ec_q) - 33'(cpe_q); end
			4'd3: begin mg = left_gains[47:32];   mx = 33'(el_q); end
			4'd4: begin mg = left_gains[31:16];   mx = 33'(li_q); end
			4'd5: begin mg = left_gains[15:0];    mx = 33'(el_q) - 33'(lpe_q); end
			4'd6: begin mg = right_gains[47:32];  mx = 33'(er_q); end
			4'd7: begin mg = right_gains[31:16];  mx = 33'(ri_q); end
			default: begin mg = right_gains[15:0]; mx = 33'(er_q) - 33'(rpe_q); end
		endcase
		mp = 49'(mg) * 49'(mx);
	end

	logic signed [63:0] mp_s1;
	logic [3:0]         idx_s1;
	logic               vld_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= cmd.mul_en;
	end
	always_ff @(posedge clk) begin
		mp_s1 <= 64'(mp);
		idx_s1 <= cmd.mul_idx;
		if (cmd.avg) begin
			ec_q <= ec_n;
			acc_l_q <= '0; acc_r_q <= '0; acc_c_q <= '0;
		end else if (vld_s1) begin
			if (idx_s1 < 4'd3) acc_c_q <= acc_c_q + mp_s1;
			else if (idx_s1 < 4'd6) acc_l_q <= acc_l_q + mp_s1;
			else acc_r_q <= acc_r_q + mp_s1;
		end
	end

	// Drive sums about 90 with line correction
	logic signed [63:0] line;
	assign line = acc_c_q > Q22One ? Q22One : (acc_c_q < -Q22One ? -Q22One : acc_c_q);
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			left_s_q  <= 64'sd90 * Q22One - (acc_l_q <<< 14)
				- (line < 0 ? 64'sd50 * line : 64'sd0);
			right_s_q <= 64'sd90 * Q22One + (acc_r_q <<< 14)
				- (line > 0 ? 64'sd50 * line : 64'sd0);
		end
	end

	// Truncate toward zero then clamp, compared as signed
	function automatic logic [7:0] clampd(input logic signed [63:0] s,
			input logic [15:0] lim);
		logic signed [63:0] v;
		v = (s < 0) ? -((-s) >>> 22) : (s >>> 22);
		if (v < $signed(64'(lim[15:8]))) return lim[15:8];
		if (v > $signed(64'(lim[7:0]))) return lim[7:0];
		return v[7:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			left_drive  <= clampd(left_s_q, limits);
			right_drive <= clampd(right_s_q, limits);
		end
		if (cmd.start) begin
			aligned     <= (lcnt_q == in_target) && (rcnt_q == in_target);
			left_count  <= lcnt_q;
			right_count <= rcnt_q;
		end
	end

	// Averaging reciprocal must stay exact against sum
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg |-> (18'(ec_n) * 3 - usum < 3 && usum - 18'(ec_n) * 3 < 3))
		else $error("divide by three mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_store |-> ddone) else $error("quotient stored early");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (tgt_q == $past(in_target))) else $error("target not latched");
endmodule

// ===== rtl/dwpl_ctrl.sv =====
// Controller state machine sequencing the datapath per control item.
// Depends on dwpl_pkg.
module dwpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [2:0]        in_mode,
	output logic              in_rdy,
	output logic              out_vld,
	input  logic              out_rdy,
	output dwpl_pkg::dp_cmd_t cmd,
	input  dwpl_pkg::dp_sts_t sts
);
	dwpl_pkg::state_t st_q, st_n;
	logic [1:0] chan_q;
	logic [3:0] midx_q;

	// Next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			dwpl_pkg::ST_IDLE:
				if (in_fire && in_mode == dwpl_pkg::MODE_STEP) st_n = dwpl_pkg::ST_ERR;
			dwpl_pkg::ST_ERR:    st_n = dwpl_pkg::ST_DIV;
			dwpl_pkg::ST_DIV:    if (sts.div_done) st_n = dwpl_pkg::ST_DIVNEXT;
			dwpl_pkg::ST_DIVNEXT:
				st_n = (chan_q == 2'd2) ? dwpl_pkg::ST_AVG : dwpl_pkg::ST_DIV;
			dwpl_pkg::ST_AVG:    st_n = dwpl_pkg::ST_MUL;
			dwpl_pkg::ST_MUL:
				if (midx_q == 4'(dwpl_pkg::NumProducts)) st_n = dwpl_pkg::ST_SUM;
			dwpl_pkg::ST_SUM:    st_n = dwpl_pkg::ST_CLAMP;
			dwpl_pkg::ST_CLAMP:  st_n = dwpl_pkg::ST_OUT;
			dwpl_pkg::ST_OUT:
				if (in_fire && in_mode == dwpl_pkg::MODE_STEP) st_n = dwpl_pkg::ST_ERR;
				else if (out_rdy) st_n = dwpl_pkg::ST_IDLE;
			default:             st_n = dwpl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= dwpl_pkg::ST_IDLE;
			chan_q <= '0;
			midx_q <= '0;
		end else begin
			st_q <= st_n;
			if (st_q == dwpl_pkg::ST_ERR) chan_q <= '0;
			else if (st_q == dwpl_pkg::ST_DIVNEXT) chan_q <= chan_q + 2'd1;
			if (st_q == dwpl_pkg::ST_AVG) midx_q <= '0;
			else if (st_q == dwpl_pkg::ST_MUL) midx_q <= midx_q + 4'd1;
		end
	end

	// Outputs
	always_comb begin
		cmd = '0;
		cmd.chan = chan_q;
		cmd.mul_idx = midx_q;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		unique case (st_q)
			dwpl_pkg::ST_IDLE: begin
				in_rdy = 1'b1;
				cmd.start = in_fire && in_mode == dwpl_pkg::MODE_STEP;
			end
			dwpl_pkg::ST_ERR: begin
				cmd.chan = 2'd0;
				cmd.div_load = 1'b1;
			end
			dwpl_pkg::ST_DIV: ;
			dwpl_pkg::ST_DIVNEXT: begin
				cmd.div_store = 1'b1;
				if (chan_q != 2'd2) begin
					cmd.div_load = 1'b1;
					cmd.chan = chan_q + 2'd1;
				end
			end
			dwpl_pkg::ST_AVG: cmd.avg = 1'b1;
			dwpl_pkg::ST_MUL: cmd.mul_en = midx_q < 4'(dwpl_pkg::NumProducts);
			dwpl_pkg::ST_SUM: cmd.sum = 1'b1;
			dwpl_pkg::ST_CLAMP: cmd.clamp = 1'b1;
			dwpl_pkg::ST_OUT: begin
				out_vld = 1'b1;
				in_rdy = out_rdy;
				// Next control item starts as the result leaves
				cmd.start = in_fire && in_mode == dwpl_pkg::MODE_STEP;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && !out_rdy |=> out_vld) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum |=> cmd.clamp) else $error("clamp not after sum");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> !cmd.mul_en) else $error("divide during multiply");
endmodule
